// File: rtl/spike_rejecting_sensor_averager_defines.svh
// Assertion macros for the spike rejecting sensor averager.
// Used by the top level only; no other dependencies.
`ifndef SPIKE_REJECTING_SENSOR_AVERAGER_DEFINES_SVH
`define SPIKE_REJECTING_SENSOR_AVERAGER_DEFINES_SVH

// same-cycle implication, gated by reset
`define SRSA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, gated by reset
`define SRSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/srsa_pkg.sv
// Shared types and constants for the spike rejecting sensor averager.
// No dependencies.
package srsa_pkg;

    localparam int SRSA_WINDOW = 8;

    localparam int TEMP_W     = 11;
    localparam int HUM_W      = 10;
    localparam int POT_W      = 12;
    localparam int PCT_W      = 10;
    localparam int Q_W        = 11;
    localparam int PROD_W     = 22;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam int STEP_W     = $clog2(Q_W);

    localparam logic [PROD_W-1:0] POT_SCALE = PROD_W'(1000);
    localparam logic [12:0]       POT_FULL  = 13'd4095;

    localparam logic [TEMP_W-1:0] TEMP_LIMIT_RST = TEMP_W'(50);
    localparam logic [HUM_W-1:0]  HUM_LIMIT_RST  = HUM_W'(100);

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_LIMIT  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_UPDATE,
        S_DIV_INIT,
        S_DIV,
        S_DIV_DONE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic accept;
        logic check;
        logic update;
        logic div_start;
        logic div_step;
        logic div_done;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic pass;
        logic div_last;
    } t_dp_stat;

endpackage

// File: rtl/srsa_ctrl.sv
// Sequencer for the averager: accept, spike check, ring update, division, output.
// Depends on srsa_pkg.
module srsa_ctrl import srsa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_stat.pass ? S_UPDATE : S_FINISH;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_DIV_DONE;
                end
            end
            S_DIV_DONE: begin
                o_cmd.div_done = 1'b1;
                n_state        = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // no request is taken while reset is held
    assign o_in_ready  = i_rst_n && (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/srsa_datapath.sv
// Datapath: sample capture, limit registers, sample ring, running sums,
// bit-serial rounding dividers, pot scaling and output register. Depends on srsa_pkg.
module srsa_datapath import srsa_pkg::*; #(
    parameter int WINDOW = SRSA_WINDOW
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_stat                 o_stat,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                     i_read_ok,
    input  logic signed [TEMP_W-1:0] i_temp_in,
    input  logic [HUM_W-1:0]         i_hum_in,
    input  logic                     i_button_low,
    input  logic [POT_W-1:0]         i_pot_raw,
    output logic                     o_valid_out,
    output logic                     o_outlier_out,
    output logic signed [TEMP_W-1:0] o_temp_avg,
    output logic [HUM_W-1:0]         o_hum_avg,
    output logic                     o_button_out,
    output logic [PCT_W-1:0]         o_pot_pct
);

    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int TSUM_W = TEMP_W + $clog2(WINDOW);
    localparam int HSUM_W = HUM_W + $clog2(WINDOW);
    localparam int DVD_W  = TSUM_W + 1;

    // limits and averaging state
    logic [TEMP_W-1:0]        r_temp_limit;
    logic [HUM_W-1:0]         r_hum_limit;
    logic [SLOT_W-1:0]        r_slot, n_slot;
    logic [CNT_W-1:0]         r_fill, n_fill;
    logic signed [TSUM_W-1:0] r_tsum, n_tsum;
    logic [HSUM_W-1:0]        r_hsum, n_hsum;
    logic signed [TEMP_W-1:0] r_held_t;
    logic [HUM_W-1:0]         r_held_h;
    logic                     r_have_good;
    logic [STEP_W-1:0]        r_step;

    // captured request
    logic                     r_ok;
    logic signed [TEMP_W-1:0] r_t;
    logic [HUM_W-1:0]         r_h;
    logic                     r_btn;
    logic [PROD_W-1:0]        r_pot_prod;
    logic                     r_outlier;

    // ring and division registers
    logic signed [TEMP_W-1:0] r_tring [WINDOW];
    logic [HUM_W-1:0]         r_hring [WINDOW];
    logic signed [TEMP_W-1:0] r_old_t;
    logic [HUM_W-1:0]         r_old_h;
    logic [CNT_W-1:0]         r_trem, r_hrem;
    logic [Q_W-1:0]           r_tq, r_hq;
    logic                     r_tneg;

    // spike check
    logic signed [TEMP_W:0]   dt;
    logic [TEMP_W:0]          adt;
    logic signed [HUM_W:0]    dh;
    logic [HUM_W:0]           adh;
    logic                     spike;

    assign dt    = TEMP_W'(0) + ((TEMP_W+1)'(r_t) - (TEMP_W+1)'(r_held_t));
    assign adt   = dt[TEMP_W] ? (TEMP_W+1)'(-dt) : (TEMP_W+1)'(dt);
    assign dh    = (HUM_W+1)'(r_h) - (HUM_W+1)'(r_held_h);
    assign adh   = dh[HUM_W] ? (HUM_W+1)'(-dh) : (HUM_W+1)'(dh);
    assign spike = (adt > {1'b0, r_temp_limit}) || (adh > {1'b0, r_hum_limit});

    assign o_stat.pass     = r_ok && !(r_have_good && spike);
    assign o_stat.div_last = (r_step == '0);

    // ring update
    logic full;
    logic signed [TEMP_W-1:0] old_t;
    logic [HUM_W-1:0]         old_h;

    assign full  = (r_fill == CNT_W'(WINDOW));
    assign old_t = full ? r_old_t : '0;
    assign old_h = full ? r_old_h : '0;

    always_comb begin
        n_tsum = r_tsum - TSUM_W'(old_t) + TSUM_W'(r_t);
        n_hsum = r_hsum - HSUM_W'(old_h) + HSUM_W'(r_h);
        n_fill = full ? r_fill : r_fill + CNT_W'(1);
        n_slot = (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + SLOT_W'(1);
    end

    // divider setup: magnitude plus half the count, rounding ties away from zero
    logic signed [DVD_W-1:0] t_ext;
    logic [DVD_W-1:0]        t_dvd, h_dvd;

    assign t_ext = DVD_W'(r_tsum);
    assign t_dvd = (t_ext[DVD_W-1] ? DVD_W'(-t_ext) : DVD_W'(t_ext))
                   + DVD_W'(r_fill >> 1);
    assign h_dvd = DVD_W'(r_hsum) + DVD_W'(r_fill >> 1);

    // one quotient bit per cycle in each divider
    logic [CNT_W:0] t_sh, h_sh;
    logic           t_ge, h_ge;

    assign t_sh = {r_trem, r_tq[Q_W-1]};
    assign h_sh = {r_hrem, r_hq[Q_W-1]};
    assign t_ge = (t_sh >= {1'b0, r_fill});
    assign h_ge = (h_sh >= {1'b0, r_fill});

    // pot scaling: x / 4095 = (x >> 12) plus one correction
    logic [PCT_W-1:0] pot_q0;
    logic [12:0]      pot_r0;
    logic [PCT_W-1:0] pot_pct;

    assign pot_q0  = r_pot_prod[PROD_W-1:12];
    assign pot_r0  = {1'b0, r_pot_prod[11:0]} + 13'(pot_q0);
    assign pot_pct = pot_q0 + PCT_W'(pot_r0 >= POT_FULL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_limit <= TEMP_LIMIT_RST;
            r_hum_limit  <= HUM_LIMIT_RST;
            r_slot       <= '0;
            r_fill       <= '0;
            r_tsum       <= '0;
            r_hsum       <= '0;
            r_held_t     <= '0;
            r_held_h     <= '0;
            r_have_good  <= 1'b0;
            r_step       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TEMP_LIMIT: r_temp_limit <= i_cfg_data[TEMP_W-1:0];
                    CFG_HUM_LIMIT:  r_hum_limit  <= i_cfg_data[HUM_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.update) begin
                r_slot      <= n_slot;
                r_fill      <= n_fill;
                r_tsum      <= n_tsum;
                r_hsum      <= n_hsum;
                r_have_good <= 1'b1;
            end
            if (i_cmd.div_start) begin
                r_step <= STEP_W'(Q_W - 1);
            end else if (i_cmd.div_step) begin
                r_step <= r_step - STEP_W'(1);
            end
            if (i_cmd.div_done) begin
                r_held_t <= r_tneg ? -$signed(r_tq) : $signed(r_tq);
                r_held_h <= HUM_W'(r_hq);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_old_t <= r_tring[r_slot];
        r_old_h <= r_hring[r_slot];
        if (i_cmd.update) begin
            r_tring[r_slot] <= r_t;
            r_hring[r_slot] <= r_h;
        end
        if (i_cmd.accept) begin
            r_ok       <= i_read_ok;
            r_t        <= i_temp_in;
            r_h        <= i_hum_in;
            r_btn      <= i_button_low;
            r_pot_prod <= PROD_W'(i_pot_raw) * POT_SCALE;
        end
        if (i_cmd.check) begin
            r_outlier <= r_ok && r_have_good && spike;
        end
        if (i_cmd.div_start) begin
            r_tneg <= r_tsum[TSUM_W-1];
            r_trem <= CNT_W'(t_dvd >> Q_W);
            r_tq   <= t_dvd[Q_W-1:0];
            r_hrem <= CNT_W'(h_dvd >> Q_W);
            r_hq   <= h_dvd[Q_W-1:0];
        end else if (i_cmd.div_step) begin
            r_trem <= t_ge ? CNT_W'(t_sh - {1'b0, r_fill}) : CNT_W'(t_sh);
            r_tq   <= {r_tq[Q_W-2:0], t_ge};
            r_hrem <= h_ge ? CNT_W'(h_sh - {1'b0, r_fill}) : CNT_W'(h_sh);
            r_hq   <= {r_hq[Q_W-2:0], h_ge};
        end
        if (i_cmd.load_out) begin
            o_valid_out   <= r_ok;
            o_outlier_out <= r_outlier;
            o_temp_avg    <= r_held_t;
            o_hum_avg     <= r_held_h;
            o_button_out  <= r_btn;
            o_pot_pct     <= pot_pct;
        end
    end

endmodule

// File: rtl/spike_rejecting_sensor_averager.sv
// Top level of the spike rejecting sensor averager.
// Depends on srsa_pkg, srsa_ctrl, srsa_datapath and the assertion macro header.
//
// One request in, one result out. A good read that stays within both spike
// limits of the last published averages enters a ring of WINDOW samples and
// new averages (running sum over fill count, rounded to nearest, ties away
// from zero) are published; failed reads and spikes return the held averages,
// zero before the first good read. A good read goes from accept through the
// two bit-serial dividers, which produce one quotient bit per cycle over 11
// steps, to result; a failed read or a spike skips the dividers. Requests are
// taken one at a time; the next can be accepted while a result is still
// waiting in the output register. Limit writes are taken at any cycle outside
// reset and must happen only while the block is idle.
`include "spike_rejecting_sensor_averager_defines.svh"

module spike_rejecting_sensor_averager import srsa_pkg::*; #(
    parameter int WINDOW = SRSA_WINDOW
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_read_ok,
    input  logic signed [TEMP_W-1:0] i_temp_in,
    input  logic [HUM_W-1:0]         i_hum_in,
    input  logic                     i_button_low,
    input  logic [POT_W-1:0]         i_pot_raw,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_valid_out,
    output logic                     o_outlier_out,
    output logic signed [TEMP_W-1:0] o_temp_avg,
    output logic [HUM_W-1:0]         o_hum_avg,
    output logic                     o_button_out,
    output logic [PCT_W-1:0]         o_pot_pct,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign o_cfg_ready = i_rst_n;

    srsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    srsa_datapath #(
        .WINDOW (WINDOW)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_read_ok     (i_read_ok),
        .i_temp_in     (i_temp_in),
        .i_hum_in      (i_hum_in),
        .i_button_low  (i_button_low),
        .i_pot_raw     (i_pot_raw),
        .o_valid_out   (o_valid_out),
        .o_outlier_out (o_outlier_out),
        .o_temp_avg    (o_temp_avg),
        .o_hum_avg     (o_hum_avg),
        .o_button_out  (o_button_out),
        .o_pot_pct     (o_pot_pct)
    );

    `SRSA_ASSERT_NOW(a_cmd_onehot, i_clk, i_rst_n,
        1'b1, $onehot0(w_cmd), "datapath commands overlap")
    `SRSA_ASSERT_NOW(a_update_pass, i_clk, i_rst_n,
        w_cmd.update, w_stat.pass, "ring update on rejected sample")
    `SRSA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n,
        i_in_valid && o_in_ready, !o_in_ready, "ready held after accept")
    `SRSA_ASSERT_NEXT(a_load_valid, i_clk, i_rst_n,
        w_cmd.load_out, o_out_valid, "result loaded without valid")

endmodule

// File: verif/tb.sv
// Self-checking testbench for spike_rejecting_sensor_averager.
// Drives directed and random samples over valid/ready and checks every result
// against typed rows or an in-bench averaging model; needs srsa_pkg, the RTL.
`timescale 1ns / 100ps

module tb import srsa_pkg::*; ();

    localparam int WIN      = SRSA_WINDOW;
    localparam int N_DIR    = 18;
    localparam int N_PHASES = 10;
    localparam int PHASE_N  = 155;

    typedef struct packed {
        logic                     ok;
        logic signed [TEMP_W-1:0] temp;
        logic [HUM_W-1:0]         hum;
        logic                     btn;
        logic [POT_W-1:0]         pot;
    } t_sample;

    typedef struct packed {
        logic                     ok;
        logic                     spike;
        logic signed [TEMP_W-1:0] temp;
        logic [HUM_W-1:0]         hum;
        logic                     btn;
        logic [PCT_W-1:0]         pct;
    } t_averages;

    typedef struct packed {
        logic                     ok;
        logic signed [TEMP_W-1:0] temp;
        logic [HUM_W-1:0]         hum;
        logic                     btn;
        logic [POT_W-1:0]         pot;
        logic                     typed;
        logic                     x_ok;
        logic                     x_spike;
        logic signed [TEMP_W-1:0] x_temp;
        logic [HUM_W-1:0]         x_hum;
        logic                     x_btn;
        logic [PCT_W-1:0]         x_pct;
    } t_dir_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic                     i_read_ok = 1'b0;
    logic signed [TEMP_W-1:0] i_temp_in = '0;
    logic [HUM_W-1:0]         i_hum_in = '0;
    logic                     i_button_low = 1'b0;
    logic [POT_W-1:0]         i_pot_raw = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic                     o_valid_out;
    logic                     o_outlier_out;
    logic signed [TEMP_W-1:0] o_temp_avg;
    logic [HUM_W-1:0]         o_hum_avg;
    logic                     o_button_out;
    logic [PCT_W-1:0]         o_pot_pct;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = CFG_TEMP_LIMIT;
    logic [CFG_DATA_W-1:0]    i_cfg_data = '0;

    spike_rejecting_sensor_averager dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_read_ok     (i_read_ok),
        .i_temp_in     (i_temp_in),
        .i_hum_in      (i_hum_in),
        .i_button_low  (i_button_low),
        .i_pot_raw     (i_pot_raw),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_valid_out   (o_valid_out),
        .o_outlier_out (o_outlier_out),
        .o_temp_avg    (o_temp_avg),
        .o_hum_avg     (o_hum_avg),
        .o_button_out  (o_button_out),
        .o_pot_pct     (o_pot_pct),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // averaging model state
    int temp_lim = int'(TEMP_LIMIT_RST);
    int hum_lim  = int'(HUM_LIMIT_RST);
    int temp_hist [WIN];
    int hum_hist  [WIN];
    int slot = 0;
    int filled = 0;
    int temp_total = 0;
    int hum_total = 0;
    int avg_temp = 0;
    int avg_hum = 0;
    bit seen_good = 1'b0;

    int n_good = 0;
    int n_spikes = 0;
    int n_failed = 0;
    int n_results = 0;
    int mismatches = 0;
    bit steady = 1'b0;

    t_averages expected_avgs [$];

    // rows 0..4 carry typed results: idle state, first good read at the
    // field extremes, a spike, a failed read, and a rounding tie both ways
    t_dir_row dir_rows [N_DIR] = '{
        '{1'b0,   800, 1000, 1'b1, 4095, 1'b1, 1'b0, 1'b0,     0,    0, 1'b1, 1000},
        '{1'b1, -1024, 1023, 1'b0,    0, 1'b1, 1'b1, 1'b0, -1024, 1023, 1'b0,    0},
        '{1'b1,  1023,    0, 1'b1, 4094, 1'b1, 1'b1, 1'b1, -1024, 1023, 1'b1,  999},
        '{1'b0,    -1,    1, 1'b0,    1, 1'b1, 1'b0, 1'b0, -1024, 1023, 1'b0,    0},
        '{1'b1, -1023, 1022, 1'b1,    5, 1'b1, 1'b1, 1'b0, -1024, 1023, 1'b1,    1},
        '{1'b1,  -974,  923, 1'b0, 2048, 1'b0, 1'b0, 1'b0,     0,    0, 1'b0,    0},
        '{1'b1,  -956,  989, 1'b1, 2047, 1'b0, 1'b0, 1'b0,     0,    0, 1'b0,    0},
        '{1'b1, -1007,  888, 1'b0, 1234, 1'b0, 1'b0, 1'b0,     0,    0, 1'b0,    0},
        '{1'b1, -1058,  989, 1'b1, 3000, 1'b0, 1'b0, 1'b0,     0,    0, 1'b0,    0},
        '{1'b1, -1000,  990, 1'b0, 4000, 1'b0, 1'b0, 1'b0,     0,    0, 1'b0,    0},
        '{1'b1, -1010, 1000, 1'b1,    2, 1'b0, 1'b0, 1'b0,     0,    0, 1'b0,    0},
        '{1'b1,  -995,  985, 1'b0, 4095, 1'b0, 1'b0, 1'b0,     0,    0, 1'b0,    0},
        '{1'b1, -1005,  995, 1'b1,  100, 1'b0, 1'b0, 1'b0,     0,    0, 1'b0,    0},
        '{1'b1, -1020, 1010, 1'b0, 2730, 1'b0, 1'b0, 1'b0,     0,    0, 1'b0,    0},
        '{1'b1,  -990,  980, 1'b1, 1365, 1'b0, 1'b0, 1'b0,     0,    0, 1'b0,    0},
        '{1'b1, -1000,  990, 1'b0,  409, 1'b0, 1'b0, 1'b0,     0,    0, 1'b0,    0},
        '{1'b1, -1015, 1005, 1'b1, 3686, 1'b0, 1'b0, 1'b0,     0,    0, 1'b0,    0},
        '{1'b0,     0,    0, 1'b1,    2, 1'b0, 1'b0, 1'b0,     0,    0, 1'b0,    0}
    };

    // round to nearest, ties away from zero
    function automatic int round_div(input int total, input int cnt);
        int mag;
        int q;
        mag = (total < 0) ? -total : total;
        q = (mag + cnt / 2) / cnt;
        return (total < 0) ? -q : q;
    endfunction

    function automatic t_averages average_sample(input t_sample s);
        t_averages r;
        int t;
        int h;
        int dt;
        int dh;
        logic spike;
        t = $signed(s.temp);
        h = s.hum;
        spike = 1'b0;
        if (s.ok) begin
            dt = (t > avg_temp) ? t - avg_temp : avg_temp - t;
            dh = (h > avg_hum) ? h - avg_hum : avg_hum - h;
            spike = seen_good && (dt > temp_lim || dh > hum_lim);
            if (!spike) begin
                if (filled == WIN) begin
                    temp_total -= temp_hist[slot];
                    hum_total -= hum_hist[slot];
                end else begin
                    filled++;
                end
                temp_hist[slot] = t;
                hum_hist[slot] = h;
                temp_total += t;
                hum_total += h;
                slot = (slot + 1) % WIN;
                avg_temp = round_div(temp_total, filled);
                avg_hum = round_div(hum_total, filled);
                seen_good = 1'b1;
                n_good++;
            end else begin
                n_spikes++;
            end
        end else begin
            n_failed++;
        end
        r.ok = s.ok;
        r.spike = spike;
        r.temp = TEMP_W'(avg_temp);
        r.hum = HUM_W'(avg_hum);
        r.btn = s.btn;
        r.pct = PCT_W'((int'(s.pot) * 1000) / 4095);
        return r;
    endfunction

    // value near a held average: mostly inside the limit, some on it or one past
    function automatic int near_avg(input int center, input int lim, input int lo,
                                    input int hi);
        int m;
        int d;
        int v;
        m = $urandom_range(9);
        if (m == 0)
            d = lim;
        else if (m == 1)
            d = lim + 1;
        else
            d = $urandom_range(lim);
        v = $urandom_range(1) ? center + d : center - d;
        if (v < lo)
            v = lo;
        if (v > hi)
            v = hi;
        return v;
    endfunction

    function automatic t_sample random_sample();
        t_sample s;
        int k;
        s.ok = 1'b1;
        s.temp = TEMP_W'($urandom);
        s.hum = HUM_W'($urandom);
        s.btn = 1'($urandom);
        s.pot = POT_W'($urandom);
        k = $urandom_range(99);
        if (k < 12) begin
            s.ok = 1'b0;
        end else if (k >= 25 && seen_good) begin
            s.temp = TEMP_W'(near_avg(avg_temp, temp_lim, -1024, 1023));
            s.hum = HUM_W'(near_avg(avg_hum, hum_lim, 0, 1023));
        end
        return s;
    endfunction

    task automatic send_sample(input t_sample s, input logic typed, input t_averages want);
        t_averages predicted;
        i_in_valid <= 1'b1;
        i_read_ok <= s.ok;
        i_temp_in <= s.temp;
        i_hum_in <= s.hum;
        i_button_low <= s.btn;
        i_pot_raw <= s.pot;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = average_sample(s);
        expected_avgs.push_back(typed ? want : predicted);
    endtask

    task automatic sender_gap();
        if (!steady && $urandom_range(99) < 25) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 40);
        end
    endtask

    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input int val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_TEMP_LIMIT)
            temp_lim = val & 'h7FF;
        else
            hum_lim = val & 'h3FF;
    endtask

    // hold off requests until every pending result is back, then retune
    task automatic retune(input int t_lim, input int h_lim);
        i_in_valid <= 1'b0;
        while (expected_avgs.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        write_limit(CFG_TEMP_LIMIT, t_lim);
        write_limit(CFG_HUM_LIMIT, h_lim);
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= 25);
    end

    always @(posedge i_clk) begin
        t_averages got;
        t_averages want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_valid_out, o_outlier_out, o_temp_avg, o_hum_avg, o_button_out, o_pot_pct};
            if (expected_avgs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d arrived with none pending", n_results);
            end else begin
                want = expected_avgs.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %0d: exp ok=%0b spike=%0b temp=%0d hum=%0d btn=%0b ",
                                  "pct=%0d, got ok=%0b spike=%0b temp=%0d hum=%0d btn=%0b ",
                                  "pct=%0d"},
                                 n_results, want.ok, want.spike, want.temp, want.hum,
                                 want.btn, want.pct, got.ok, got.spike, got.temp, got.hum,
                                 got.btn, got.pct);
                end
            end
            n_results++;
        end
    end

    initial begin
        t_sample   s;
        t_averages want;
        t_dir_row  row;
        int        t_set [N_PHASES];
        int        h_set [N_PHASES];
        int        p;
        int        k;

        t_set = '{0, 2047, 1200, 50, 1, 0, 20, 2047, 0, 0};
        h_set = '{0, 1023, 1000, 100, 1, 0, 40, 0, 1023, 0};
        t_set[5] = $urandom_range(1200);
        h_set[5] = $urandom_range(1000);
        t_set[9] = $urandom_range(2047);
        h_set[9] = $urandom_range(1023);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < N_DIR; k++) begin
            row = dir_rows[k];
            s = '{row.ok, row.temp, row.hum, row.btn, row.pot};
            want = '{row.x_ok, row.x_spike, row.x_temp, row.x_hum, row.x_btn, row.x_pct};
            sender_gap();
            send_sample(s, row.typed, want);
        end

        for (p = 0; p < N_PHASES; p++) begin
            retune(t_set[p], h_set[p]);
            steady = (p == 3);
            for (k = 0; k < PHASE_N; k++) begin
                sender_gap();
                send_sample(random_sample(), 1'b0, '0);
            end
        end
        steady = 1'b0;
        i_in_valid <= 1'b0;

        k = 0;
        while (expected_avgs.size() != 0 && k < 2000) begin
            @(posedge i_clk);
            k++;
        end
        repeat (20) @(posedge i_clk);
        if (expected_avgs.size() != 0) begin
            $display("%0d results never arrived", expected_avgs.size());
            mismatches += expected_avgs.size();
        end

        $display("Ran %0d samples: %0d averaged, %0d spikes rejected, %0d failed reads,",
                 n_good + n_spikes + n_failed, n_good, n_spikes, n_failed);
        $display("across %0d limit settings; %0d results checked, %0d mismatches.",
                 N_PHASES + 1, n_results, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
